// ===== hdl/arre_pkg.sv =====
// ============================================================================
// arre_pkg
// Shared types and constants for the acknowledgement range record encoder.
// ============================================================================
package arre_pkg;

    localparam int SEQ_W               = 24;
    localparam int IDX_W               = 9;
    localparam int OP_W                = 2;
    localparam int MAX_ENTRIES_DEFAULT = 256;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_READ,
        CMD_CLEAR,
        CMD_IGNORE
    } cmd_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_RFIRST,
        S_RWALK,
        S_RECORD,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SEQ_W-1:0] seq_number;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic             record_single;
        logic [SEQ_W-1:0] range_first;
        logic [SEQ_W-1:0] range_final;
        logic [IDX_W-1:0] record_index;
        logic             last_record;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [SEQ_W-1:0] value;
    } cmd_t;

endpackage

// ===== hdl/ack_range_record_encoder.sv =====
// ============================================================================
// ack_range_record_encoder
// Sorted, duplicate-free table of sequence numbers read back as ack records.
// ============================================================================
// Usage: items enter through push/full as one in_item_t beat; results leave
// through empty/pop as one out_item_t beat, exactly one per item, in order.
// A two-entry input queue takes beats while the table engine works and while
// a finished result still waits in the output register.
// The engine handles one item at a time with one table memory that has a
// registered read port. Steps per item, once the engine takes it:
//   insert: search from the start for the first entry not below the number,
//           which ends the item on a duplicate or a full table, else shift
//           the entries from there up by one, top first, and place the number;
//   read:   merge the run of consecutive numbers from the walk pointer into
//           one record;
//   clear, unused codes and reads past the end: straight to the result.
// Reset empties the table, rewinds the walk and drops queued beats; the table
// memory is not cleared, since only entries below the count are ever read.
// When pop stays low, the engine finishes into its pending register and waits,
// the input queue fills, and full rises after two further beats.
// ============================================================================
module ack_range_record_encoder #(
    parameter int MAX_ENTRIES = arre_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  arre_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output arre_pkg::out_item_t result
);

    import arre_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    arre_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    arre_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== hdl/arre_ram.sv =====
// ============================================================================
// arre_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module arre_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/arre_front.sv =====
// ============================================================================
// arre_front
// Input queue that accepts beats, classifies the operation and buffers the
// resulting commands for the table engine.
// ============================================================================
module arre_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  arre_pkg::in_item_t item,
    output logic              cmd_valid,
    output arre_pkg::cmd_t    cmd,
    input  logic              cmd_take
);

    import arre_pkg::*;

    localparam int QD  = 2;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    cmd_t             slot_reg [QD];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    cmd_t             new_cmd;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        new_cmd.value = item.seq_number;
        unique case (item.operation)
            OP_INSERT: new_cmd.kind = CMD_INSERT;
            OP_READ:   new_cmd.kind = CMD_READ;
            OP_CLEAR:  new_cmd.kind = CMD_CLEAR;
            OP_UNUSED: new_cmd.kind = CMD_IGNORE;
        endcase
    end

    assign full      = (cnt_reg == QCW'(QD));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== hdl/arre_engine.sv =====
// ============================================================================
// arre_engine
// Table engine: sorted insertion by search and shift, run-merging record
// reads, clearing, and the output register that holds one result beat.
// ============================================================================
module arre_engine #(
    parameter int MAX_ENTRIES = arre_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  arre_pkg::cmd_t     cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output arre_pkg::out_item_t result
);

    import arre_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    eng_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    re_reg, re_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [SEQ_W-1:0] val_reg, val_next;
    logic [SEQ_W-1:0] first_reg, first_next;
    logic [SEQ_W-1:0] last_reg, last_next;
    out_item_t        pend_reg, pend_next;
    out_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SEQ_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [SEQ_W-1:0] ram_rdata;

    logic [CW-1:0]    idx_plus;
    logic [CW-1:0]    idx_minus;
    logic [CW-1:0]    count_minus;
    logic [CW-1:0]    rp_plus;
    logic [SEQ_W:0]   last_inc;
    logic             table_full;

    arre_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_plus    = idx_reg + 1'b1;
    assign idx_minus   = idx_reg - 1'b1;
    assign count_minus = count_reg - 1'b1;
    assign rp_plus     = rp_reg + 1'b1;
    assign last_inc    = {1'b0, last_reg} + 1'b1;
    assign table_full  = (count_reg == CW'(MAX_ENTRIES));

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rp_next        = rp_reg;
        re_next        = re_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        cmd_take       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = val_reg;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take  = 1'b1;
                    pend_next = '0;
                    unique case (cmd.kind)
                        CMD_INSERT:
                        begin
                            val_next = cmd.value;
                            if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                ram_raddr  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_READ:
                        begin
                            if (rp_reg >= count_reg)
                            begin
                                pend_next.status = ST_NONE;
                                state_next       = S_DONE;
                            end
                            else
                            begin
                                ram_raddr  = rp_reg[AW-1:0];
                                state_next = S_RFIRST;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            rp_next    = '0;
                            re_next    = '0;
                            state_next = S_DONE;
                        end
                        CMD_IGNORE:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                priority if (ram_rdata == val_reg)
                begin
                    pend_next.status = ST_DUP;
                    state_next       = S_DONE;
                end
                else if (ram_rdata < val_reg)
                begin
                    if (idx_plus == count_reg)
                    begin
                        if (table_full)
                        begin
                            pend_next.status = ST_FULL;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            state_next = S_PLACE;
                        end
                    end
                    else
                    begin
                        idx_next  = idx_plus;
                        ram_raddr = idx_plus[AW-1:0];
                    end
                end
                else
                begin
                    if (table_full)
                    begin
                        pend_next.status = ST_FULL;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_minus;
                        ram_raddr  = count_minus[AW-1:0];
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_plus[AW-1:0];
                ram_wdata = ram_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next  = idx_minus;
                    ram_raddr = idx_minus[AW-1:0];
                end
            end

            S_PLACE:
            begin
                ram_we           = 1'b1;
                ram_waddr        = pos_reg[AW-1:0];
                ram_wdata        = val_reg;
                count_next       = count_reg + 1'b1;
                rp_next          = '0;
                re_next          = '0;
                pend_next.status = ST_OK;
                state_next       = S_DONE;
            end

            S_RFIRST:
            begin
                first_next = ram_rdata;
                last_next  = ram_rdata;
                rp_next    = rp_plus;
                if (rp_plus < count_reg)
                begin
                    ram_raddr  = rp_plus[AW-1:0];
                    state_next = S_RWALK;
                end
                else
                begin
                    state_next = S_RECORD;
                end
            end

            S_RWALK:
            begin
                if ({1'b0, ram_rdata} == last_inc)
                begin
                    last_next = ram_rdata;
                    rp_next   = rp_plus;
                    if (rp_plus < count_reg)
                    begin
                        ram_raddr = rp_plus[AW-1:0];
                    end
                    else
                    begin
                        state_next = S_RECORD;
                    end
                end
                else
                begin
                    state_next = S_RECORD;
                end
            end

            S_RECORD:
            begin
                pend_next.status        = ST_OK;
                pend_next.record_single = (first_reg == last_reg);
                pend_next.range_first   = first_reg;
                pend_next.range_final   = last_reg;
                pend_next.record_index  = IDX_W'(re_reg);
                pend_next.last_record   = (rp_reg >= count_reg);
                re_next                 = re_reg + 1'b1;
                state_next              = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            re_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            re_reg        <= re_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the acknowledgement range record encoder.
// ============================================================================
// Items are queued by the stimulus block and sent through push/full with
// random gaps. Each accepted beat is run through a local copy of the sorted
// sequence table, and the result it should produce is queued. Result beats
// are taken through empty/pop with random stalls and compared field by field
// against the oldest queued result. The stimulus covers directed corner
// cases, then random insert/read sessions, mixed bursts, noise, and two full-table fills.
// ============================================================================
module tb;

    import arre_pkg::*;

    localparam int TABLE_DEPTH   = MAX_ENTRIES_DEFAULT;
    localparam int ITEM_TARGET   = 1600;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 100;
    localparam int IDLE_LIMIT    = 8 * (2 * TABLE_DEPTH + 40);

    typedef struct {
        bit       drain;
        in_item_t beat;
    } pending_beat_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    pending_beat_t pending_beats[$];
    out_item_t     expected_records[$];

    logic [SEQ_W-1:0] seq_table [TABLE_DEPTH];
    int unsigned      table_count;
    int unsigned      walk_ptr;
    int unsigned      records_sent;

    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned tx_gap;
    int unsigned tx_streak;
    int unsigned rx_stall;
    int unsigned rx_streak;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned stim_count;
    int unsigned n_records;
    int unsigned n_dup;
    int unsigned n_full;
    int unsigned n_none;

    ack_range_record_encoder #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic out_item_t step_ack_table(in_item_t beat);
        out_item_t        r;
        int unsigned      pos;
        int unsigned      i;
        logic [SEQ_W-1:0] run_start;
        logic [SEQ_W:0]   run_end;
        r = '0;
        r.status = ST_OK;
        if (beat.operation == OP_INSERT)
        begin
            pos = 0;
            while (pos < table_count && seq_table[pos] < beat.seq_number)
                pos++;
            if (pos < table_count && seq_table[pos] == beat.seq_number)
            begin
                r.status = ST_DUP;
                n_dup++;
            end
            else if (table_count >= TABLE_DEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                for (i = table_count; i > pos; i--)
                    seq_table[i] = seq_table[i-1];
                seq_table[pos] = beat.seq_number;
                table_count++;
                walk_ptr = 0;
                records_sent = 0;
            end
        end
        else if (beat.operation == OP_READ)
        begin
            if (walk_ptr >= table_count)
            begin
                r.status = ST_NONE;
                n_none++;
            end
            else
            begin
                run_start = seq_table[walk_ptr];
                run_end = {1'b0, run_start};
                walk_ptr++;
                while (walk_ptr < table_count && {1'b0, seq_table[walk_ptr]} == run_end + 1)
                begin
                    run_end = {1'b0, seq_table[walk_ptr]};
                    walk_ptr++;
                end
                r.record_single = (run_start == run_end[SEQ_W-1:0]);
                r.range_first   = run_start;
                r.range_final   = run_end[SEQ_W-1:0];
                r.record_index  = records_sent[IDX_W-1:0];
                r.last_record   = (walk_ptr >= table_count);
                records_sent++;
                n_records++;
            end
        end
        else if (beat.operation == OP_CLEAR)
        begin
            table_count = 0;
            walk_ptr = 0;
            records_sent = 0;
        end
        return r;
    endfunction

    function automatic int unsigned draw_wait(inout int unsigned streak);
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", beats_out, msg);
        fail_count++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
    endtask

    task automatic queue_beat(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq);
        pending_beat_t p;
        p.drain = 1'b0;
        p.beat.operation = op;
        p.beat.seq_number = seq;
        pending_beats = {pending_beats, p};
        if (op != OP_UNUSED)
            stim_count++;
    endtask

    task automatic queue_drain();
        pending_beat_t p;
        p.drain = 1'b1;
        p.beat = '0;
        pending_beats = {pending_beats, p};
    endtask

    task automatic queue_session();
        int unsigned      k;
        int unsigned      i;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] v;
        if ($urandom_range(0, 2) != 0)
            queue_beat(OP_CLEAR, SEQ_W'($urandom));
        k = $urandom_range(1, 24);
        base = SEQ_W'($urandom);
        v = base;
        for (i = 0; i < k; i++)
        begin
            if (i == 0 || $urandom_range(0, 7) != 0)
                v = base + SEQ_W'($urandom_range(0, 2 * k));
            queue_beat(OP_INSERT, v);
        end
        for (i = 0; i < k + 2; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_beat(OP_INSERT, base + SEQ_W'($urandom_range(0, 2 * k)));
            queue_beat(OP_READ, SEQ_W'($urandom));
        end
    endtask

    task automatic queue_fill(bit sparse);
        logic [SEQ_W-1:0] vals[$];
        logic [SEQ_W-1:0] v;
        logic [SEQ_W-1:0] t;
        int unsigned      i;
        int unsigned      j;
        queue_beat(OP_CLEAR, SEQ_W'($urandom));
        v = SEQ_W'($urandom);
        for (i = 0; i < TABLE_DEPTH + 4; i++)
        begin
            v = v + SEQ_W'((sparse || $urandom_range(0, 3) == 0) ? 2 : 1);
            vals = {vals, v};
        end
        for (i = vals.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
        end
        foreach (vals[n])
            queue_beat(OP_INSERT, vals[n]);
        queue_beat(OP_INSERT, vals[0]);
        for (i = 0; i < TABLE_DEPTH + 1; i++)
            queue_beat(OP_READ, SEQ_W'($urandom));
    endtask

    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(1, 10);
        repeat (n)
            queue_beat(OP_W'($urandom_range(0, 3)), SEQ_W'($urandom));
    endtask

    task automatic queue_broken();
        int unsigned      n;
        logic [SEQ_W-1:0] base;
        n = $urandom_range(3, 12);
        base = SEQ_W'($urandom);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0, 1: queue_beat(OP_INSERT, base + SEQ_W'($urandom_range(0, 6)));
                2:    queue_beat(OP_CLEAR, SEQ_W'($urandom));
                default: queue_beat(OP_READ, SEQ_W'($urandom));
            endcase
        end
    endtask

    task automatic queue_directed();
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_INSERT, 24'h000000);
        queue_beat(OP_INSERT, 24'hFFFFFF);
        queue_beat(OP_INSERT, 24'h000000);
        queue_beat(OP_INSERT, 24'h000001);
        queue_beat(OP_INSERT, 24'h000003);
        queue_beat(OP_INSERT, 24'h000002);
        queue_beat(OP_INSERT, 24'h800000);
        queue_beat(OP_READ, 24'hFFFFFF);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_INSERT, 24'hFFFFFE);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_UNUSED, 24'hA5A5A5);
        queue_beat(OP_CLEAR, 24'h5A5A5A);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_INSERT, 24'h555555);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_READ, 24'h000000);
        queue_beat(OP_UNUSED, 24'hFFFFFF);
        queue_beat(OP_CLEAR, 24'h000000);
        queue_drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        pending_beat_t next_beat;
        if (!rst_n)
        begin
            push      <= 1'b0;
            item      <= '0;
            tx_gap    <= 0;
            tx_streak <= 0;
            beats_in  <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_records = {expected_records, step_ack_table(item)};
                beats_in <= beats_in + 1;
            end
            if (!(push && full))
            begin
                if (tx_gap != 0)
                begin
                    push   <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (pending_beats.size() != 0 && pending_beats[0].drain)
                begin
                    push <= 1'b0;
                    if (!push && beats_in == beats_out)
                        void'(pending_beats.pop_front());
                end
                else if (pending_beats.size() != 0)
                begin
                    next_beat = pending_beats.pop_front();
                    item   <= next_beat.beat;
                    push   <= 1'b1;
                    tx_gap <= draw_wait(tx_streak);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t   want;
        int unsigned d;
        if (!rst_n)
        begin
            pop       <= 1'b0;
            rx_stall  <= 0;
            rx_streak <= 0;
            beats_out <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                beats_out <= beats_out + 1;
                if (expected_records.size() == 0)
                begin
                    report_mismatch("result beat with no item waiting");
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("status", 32'(result.status), 32'(want.status));
                    check_field("record_single", 32'(result.record_single),
                                32'(want.record_single));
                    check_field("range_first", 32'(result.range_first),
                                32'(want.range_first));
                    check_field("range_final", 32'(result.range_final),
                                32'(want.range_final));
                    check_field("record_index", 32'(result.record_index),
                                32'(want.record_index));
                    check_field("last_record", 32'(result.last_record),
                                32'(want.last_record));
                end
                d = draw_wait(rx_streak);
                if (d == 0)
                begin
                    pop <= 1'b1;
                end
                else
                begin
                    pop      <= 1'b0;
                    rx_stall <= d - 1;
                end
            end
            else if (rx_stall != 0)
            begin
                pop      <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned fills_done;
        table_count  = 0;
        walk_ptr     = 0;
        records_sent = 0;
        fail_count   = 0;
        stim_count   = 0;
        n_records    = 0;
        n_dup        = 0;
        n_full       = 0;
        n_none       = 0;
        fills_done   = 0;

        queue_directed();
        while (stim_count < ITEM_TARGET)
        begin
            if (fills_done < 2 && stim_count > 400 * (fills_done + 1))
            begin
                queue_fill(fills_done == 0);
                fills_done++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: queue_session();
                6: queue_noise();
                7: queue_broken();
                default:
                begin
                    queue_drain();
                    queue_session();
                end
            endcase
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || push)
            @(posedge clk);
        while (beats_in != beats_out)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_records.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_records.size()));

        $display("Sent %0d beats; %0d records read, %0d reads past the end.",
                 beats_in, n_records, n_none);
        $display("Inserts: %0d duplicates ignored, %0d dropped on a full table.",
                 n_dup, n_full);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/arre_pkg.sv
hdl/arre_ram.sv
hdl/arre_front.sv
hdl/arre_engine.sv
hdl/ack_range_record_encoder.sv
test/tb.sv
